// ===== src/srpl_pkg.sv =====
// ----------------------------------------------------------------------------
// srpl_pkg: shared types and constants for the fixed-string replace unit
// Field widths, configuration register map and the burst descriptor that
// travels from the matcher to the output stage.
// ----------------------------------------------------------------------------
package srpl_pkg;

    // Default sizes of the hold window and of the replacement string
    localparam int MAX_PATTERN_DEF     = 8;
    localparam int MAX_REPLACEMENT_DEF = 8;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 16;
    localparam int STRING_W  = 64;
    localparam int LENGTH_W  = 4;

    // Configuration port: 64-bit registers at 8-byte spacing
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 6;
    localparam int REG_IDX_LSB = 3;
    localparam int REG_IDX_W   = APB_AW - REG_IDX_LSB;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_BYTES      = 3'd0,
        REG_PATTERN_LENGTH     = 3'd1,
        REG_REPLACEMENT_BYTES  = 3'd2,
        REG_REPLACEMENT_LENGTH = 3'd3,
        REG_LIMIT_ENABLE       = 3'd4,
        REG_REPLACE_LIMIT      = 3'd5
    } t_reg_idx;

    // Attributes shared by every word of one burst
    typedef struct packed {
        logic               present;
        logic               last;
        logic [TOTAL_W-1:0] total;
    } t_burst_meta;

endpackage

// ===== src/srpl_cell.sv =====
// ----------------------------------------------------------------------------
// srpl_cell: one stage of the hold window
// Holds one byte, takes its neighbor's byte on every accepted word and
// compares the incoming byte against the pattern byte aimed at this stage.
// ----------------------------------------------------------------------------
module srpl_cell (
    input  logic                        i_clk,
    input  logic                        i_shift,
    input  logic [srpl_pkg::BYTE_W-1:0] i_data,
    input  logic [srpl_pkg::BYTE_W-1:0] i_expected,
    output logic [srpl_pkg::BYTE_W-1:0] o_data,
    output logic                        o_equal
);
    import srpl_pkg::*;

    logic [BYTE_W-1:0] r_data;

    // Advance the byte along the chain
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    // Compare the byte that enters this stage
    assign o_equal = (i_data == i_expected);
    assign o_data  = r_data;

endmodule

// ===== src/srpl_matcher.sv =====
// ----------------------------------------------------------------------------
// srpl_matcher: hold window, pattern compare and replacement counter
// A chain of cells keeps the newest bytes, newest in stage 0. Each accepted
// word shifts the chain, checks for a full-window match and builds the list
// of words it releases, stored top-down so the head sits at count-1.
// ----------------------------------------------------------------------------
module srpl_matcher #(
    parameter  int MAX_PATTERN     = srpl_pkg::MAX_PATTERN_DEF,
    parameter  int MAX_REPLACEMENT = srpl_pkg::MAX_REPLACEMENT_DEF,
    localparam int BURST_DEPTH     = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                     MAX_PATTERN : MAX_REPLACEMENT,
    localparam int CNT_W           = $clog2(BURST_DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [srpl_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_in_last,
    input  logic [srpl_pkg::STRING_W-1:0] i_pattern_bytes,
    input  logic [srpl_pkg::LENGTH_W-1:0] i_pattern_length,
    input  logic [srpl_pkg::STRING_W-1:0] i_replacement_bytes,
    input  logic [srpl_pkg::LENGTH_W-1:0] i_replacement_length,
    input  logic                          i_limit_enable,
    input  logic [srpl_pkg::TOTAL_W-1:0]  i_replace_limit,
    output logic [CNT_W-1:0]              o_count,
    output logic [srpl_pkg::BYTE_W-1:0]   o_bytes [BURST_DEPTH],
    output logic [srpl_pkg::BYTE_W-1:0]   o_first_byte,
    output srpl_pkg::t_burst_meta         o_meta
);
    import srpl_pkg::*;

    localparam int HC_W = $clog2(MAX_PATTERN + 1);

    logic [HC_W-1:0]    r_hold_count;
    logic [HC_W-1:0]    n_hold_count;
    logic [TOTAL_W-1:0] r_replace_count;
    logic [TOTAL_W-1:0] n_replace_count;

    logic [HC_W-1:0]    plen;
    logic [HC_W-1:0]    plen_m1;
    logic [HC_W-1:0]    kept;
    logic [HC_W-1:0]    fill;
    logic [CNT_W-1:0]   rlen;

    logic [BYTE_W-1:0]  cell_in  [MAX_PATTERN];
    logic [BYTE_W-1:0]  cell_q   [MAX_PATTERN];
    logic [BYTE_W-1:0]  expected [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] cell_eq;

    logic               full;
    logic               allowed;
    logic               all_eq;
    logic               hit;
    logic [BYTE_W-1:0]  oldest;
    logic [TOTAL_W-1:0] total;
    logic               present;

    // Clamp the configured lengths
    always_comb begin
        if (i_pattern_length == '0) begin
            plen = HC_W'(1);
        end else if (int'(i_pattern_length) > MAX_PATTERN) begin
            plen = HC_W'(MAX_PATTERN);
        end else begin
            plen = HC_W'(i_pattern_length);
        end
        if (int'(i_replacement_length) > MAX_REPLACEMENT) begin
            rlen = CNT_W'(MAX_REPLACEMENT);
        end else begin
            rlen = CNT_W'(i_replacement_length);
        end
    end

    // Drop surplus old bytes, then count the incoming one
    assign plen_m1 = plen - 1'b1;
    assign kept    = (r_hold_count > plen_m1) ? plen_m1 : r_hold_count;
    assign fill    = kept + 1'b1;
    assign full    = (fill == plen);

    // Pattern byte seen by each stage when the window is full
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            expected[k] = '0;
            for (int j = 0; j < MAX_PATTERN; j++) begin
                if (int'(plen) - 1 - k == j) begin
                    expected[k] = i_pattern_bytes[BYTE_W*j +: BYTE_W];
                end
            end
        end
    end

    // Window chain
    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign cell_in[k] = i_in_byte;
        end else begin : g_body
            assign cell_in[k] = cell_q[k-1];
        end
        srpl_cell u_cell (
            .i_clk      (i_clk),
            .i_shift    (i_accept),
            .i_data     (cell_in[k]),
            .i_expected (expected[k]),
            .o_data     (cell_q[k]),
            .o_equal    (cell_eq[k])
        );
    end

    // Match decision and oldest byte of the shifted window
    always_comb begin
        all_eq = 1'b1;
        oldest = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (k < int'(plen) && !cell_eq[k]) begin
                all_eq = 1'b0;
            end
            if (k == int'(fill) - 1) begin
                oldest = cell_in[k];
            end
        end
    end

    assign allowed = !(i_limit_enable && (r_replace_count >= i_replace_limit));
    assign hit     = full && allowed && all_eq;
    assign total   = (hit && (r_replace_count != '1)) ?
                     r_replace_count + 1'b1 : r_replace_count;

    // Build the released words, head at index count-1
    always_comb begin
        o_bytes      = '{default: '0};
        o_count      = '0;
        o_first_byte = '0;
        present      = 1'b1;
        if (hit) begin
            o_count      = rlen;
            o_first_byte = i_replacement_bytes[BYTE_W-1:0];
            for (int k = 0; k < BURST_DEPTH; k++) begin
                for (int j = 0; j < MAX_REPLACEMENT; j++) begin
                    if (int'(rlen) - 1 - k == j) begin
                        o_bytes[k] = i_replacement_bytes[BYTE_W*j +: BYTE_W];
                    end
                end
            end
        end else if (i_in_last) begin
            o_count      = CNT_W'(fill);
            o_first_byte = oldest;
            for (int k = 0; k < MAX_PATTERN; k++) begin
                o_bytes[k] = cell_in[k];
            end
        end else if (full) begin
            o_count      = CNT_W'(1);
            o_first_byte = oldest;
            o_bytes[0]   = oldest;
        end
        // Nothing to release at the end of a stream: a count-only word
        if (i_in_last && (o_count == '0)) begin
            o_count      = CNT_W'(1);
            o_first_byte = '0;
            o_bytes[0]   = '0;
            present      = 1'b0;
        end
    end

    assign o_meta = '{present: present, last: i_in_last, total: total};

    // Window fill and replacement count
    always_comb begin
        n_hold_count    = r_hold_count;
        n_replace_count = r_replace_count;
        if (i_accept) begin
            if (i_in_last) begin
                n_hold_count    = '0;
                n_replace_count = '0;
            end else begin
                n_replace_count = total;
                if (hit) begin
                    n_hold_count = '0;
                end else if (full) begin
                    n_hold_count = plen_m1;
                end else begin
                    n_hold_count = fill;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_count    <= '0;
            r_replace_count <= '0;
        end else begin
            r_hold_count    <= n_hold_count;
            r_replace_count <= n_replace_count;
        end
    end

endmodule

// ===== src/srpl_emit.sv =====
// ----------------------------------------------------------------------------
// srpl_emit: burst buffer and output register
// Takes the words released by one input word. The head goes straight to the
// output register when it is free; the rest wait in the burst buffer and
// leave one per cycle unless stalled; input waits until the buffer is empty.
// ----------------------------------------------------------------------------
module srpl_emit #(
    parameter  int BURST_DEPTH = srpl_pkg::MAX_PATTERN_DEF,
    localparam int CNT_W       = $clog2(BURST_DEPTH + 1),
    localparam int IDX_W       = (BURST_DEPTH > 1) ? $clog2(BURST_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  logic [CNT_W-1:0]             i_count,
    input  logic [srpl_pkg::BYTE_W-1:0]  i_bytes [BURST_DEPTH],
    input  logic [srpl_pkg::BYTE_W-1:0]  i_first_byte,
    input  srpl_pkg::t_burst_meta        i_meta,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [srpl_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                         o_byte_present,
    output logic                         o_out_last,
    output logic [srpl_pkg::TOTAL_W-1:0] o_replace_total
);
    import srpl_pkg::*;

    logic [BYTE_W-1:0]  r_buf [BURST_DEPTH];
    logic [BYTE_W-1:0]  n_buf [BURST_DEPTH];
    logic [CNT_W-1:0]   r_left;
    logic [CNT_W-1:0]   n_left;
    t_burst_meta        r_meta;
    t_burst_meta        n_meta;

    logic               r_out_valid;
    logic               n_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic [BYTE_W-1:0]  n_out_byte;
    logic               r_out_present;
    logic               n_out_present;
    logic               r_out_last;
    logic               n_out_last;
    logic [TOTAL_W-1:0] r_out_total;
    logic [TOTAL_W-1:0] n_out_total;

    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // Drain the buffer first, else buffer a new burst or pass its head through
    always_comb begin
        n_buf         = r_buf;
        n_left        = r_left;
        n_meta        = r_meta;
        n_out_valid   = r_out_valid && !i_out_ready;
        n_out_byte    = r_out_byte;
        n_out_present = r_out_present;
        n_out_last    = r_out_last;
        n_out_total   = r_out_total;
        if (r_left != '0) begin
            if (out_free) begin
                n_out_valid   = 1'b1;
                n_out_byte    = r_buf[IDX_W'(r_left - 1'b1)];
                n_out_present = r_meta.present;
                n_out_last    = r_meta.last && (r_left == CNT_W'(1));
                n_out_total   = r_meta.total;
                n_left        = r_left - 1'b1;
            end
        end else if (i_load && (i_count != '0)) begin
            n_buf  = i_bytes;
            n_meta = i_meta;
            if (out_free) begin
                n_out_valid   = 1'b1;
                n_out_byte    = i_first_byte;
                n_out_present = i_meta.present;
                n_out_last    = i_meta.last && (i_count == CNT_W'(1));
                n_out_total   = i_meta.total;
                n_left        = i_count - 1'b1;
            end else begin
                n_left = i_count;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_buf         <= n_buf;
        r_meta        <= n_meta;
        r_out_byte    <= n_out_byte;
        r_out_present <= n_out_present;
        r_out_last    <= n_out_last;
        r_out_total   <= n_out_total;
    end

    assign o_in_ready      = (r_left == '0);
    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_byte_present  = r_out_present;
    assign o_out_last      = r_out_last;
    assign o_replace_total = r_out_total;

endmodule

// ===== src/stream_fixed_string_replace_unit.sv =====
// ----------------------------------------------------------------------------
// stream_fixed_string_replace_unit: streaming fixed-string find and replace
// Replaces leftmost non-overlapping occurrences of a literal pattern in a byte
// stream (up to an optional limit); reports the saturating replacement count.
// ----------------------------------------------------------------------------
// Plain text, whose bytes release at most one output word each, flows at one
// byte per cycle while the output is not stalled. A match releases R
// replacement words and the last byte releases the held window (up to the
// pattern length); these leave through the single output register at one
// word per cycle unless stalled; input pauses until the burst buffer is empty.
// One input word may still be taken while a finished word waits at the output.
// Registers sit on the APB port at byte address 8*i; write them only while the
// stream is idle.
module stream_fixed_string_replace_unit #(
    parameter int MAX_PATTERN     = srpl_pkg::MAX_PATTERN_DEF,
    parameter int MAX_REPLACEMENT = srpl_pkg::MAX_REPLACEMENT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input stream
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [srpl_pkg::BYTE_W-1:0]   i_in_byte,
    input  logic                          i_in_last,
    // output stream
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [srpl_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_byte_present,
    output logic                          o_out_last,
    output logic [srpl_pkg::TOTAL_W-1:0]  o_replace_total,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srpl_pkg::APB_AW-1:0]   paddr,
    input  logic [srpl_pkg::APB_DW-1:0]   pwdata,
    output logic [srpl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import srpl_pkg::*;

    localparam int BURST_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ?
                                 MAX_PATTERN : MAX_REPLACEMENT;
    localparam int CNT_W       = $clog2(BURST_DEPTH + 1);

    logic [STRING_W-1:0] r_pattern_bytes;
    logic [LENGTH_W-1:0] r_pattern_length;
    logic [STRING_W-1:0] r_replacement_bytes;
    logic [LENGTH_W-1:0] r_replacement_length;
    logic                r_limit_enable;
    logic [TOTAL_W-1:0]  r_replace_limit;

    t_reg_idx            reg_idx;
    logic                cfg_write;
    logic                accept;

    logic [CNT_W-1:0]    burst_count;
    logic [BYTE_W-1:0]   burst_bytes [BURST_DEPTH];
    logic [BYTE_W-1:0]   burst_first;
    t_burst_meta         burst_meta;

    // Register access
    assign pready    = 1'b1;
    assign reg_idx   = t_reg_idx'(paddr[APB_AW-1:REG_IDX_LSB]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes      <= '0;
            r_pattern_length     <= LENGTH_W'(1);
            r_replacement_bytes  <= '0;
            r_replacement_length <= '0;
            r_limit_enable       <= 1'b0;
            r_replace_limit      <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_PATTERN_BYTES:      r_pattern_bytes      <= pwdata;
                REG_PATTERN_LENGTH:     r_pattern_length     <= pwdata[LENGTH_W-1:0];
                REG_REPLACEMENT_BYTES:  r_replacement_bytes  <= pwdata;
                REG_REPLACEMENT_LENGTH: r_replacement_length <= pwdata[LENGTH_W-1:0];
                REG_LIMIT_ENABLE:       r_limit_enable       <= pwdata[0];
                REG_REPLACE_LIMIT:      r_replace_limit      <= pwdata[TOTAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_PATTERN_BYTES:      prdata = r_pattern_bytes;
            REG_PATTERN_LENGTH:     prdata = APB_DW'(r_pattern_length);
            REG_REPLACEMENT_BYTES:  prdata = r_replacement_bytes;
            REG_REPLACEMENT_LENGTH: prdata = APB_DW'(r_replacement_length);
            REG_LIMIT_ENABLE:       prdata = APB_DW'(r_limit_enable);
            REG_REPLACE_LIMIT:      prdata = APB_DW'(r_replace_limit);
            default:                prdata = '0;
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    // Window and matching
    srpl_matcher #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_matcher (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_accept             (accept),
        .i_in_byte            (i_in_byte),
        .i_in_last            (i_in_last),
        .i_pattern_bytes      (r_pattern_bytes),
        .i_pattern_length     (r_pattern_length),
        .i_replacement_bytes  (r_replacement_bytes),
        .i_replacement_length (r_replacement_length),
        .i_limit_enable       (r_limit_enable),
        .i_replace_limit      (r_replace_limit),
        .o_count              (burst_count),
        .o_bytes              (burst_bytes),
        .o_first_byte         (burst_first),
        .o_meta               (burst_meta)
    );

    // Output burst handling
    srpl_emit #(
        .BURST_DEPTH (BURST_DEPTH)
    ) u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (accept),
        .i_count         (burst_count),
        .i_bytes         (burst_bytes),
        .i_first_byte    (burst_first),
        .i_meta          (burst_meta),
        .o_in_ready      (o_in_ready),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_present  (o_byte_present),
        .o_out_last      (o_out_last),
        .o_replace_total (o_replace_total)
    );

endmodule

// ===== src/srpl_checker.sv =====
// ----------------------------------------------------------------------------
// srpl_checker: port-level checks for the fixed-string replace unit
// Watches the output stream and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
module srpl_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic [srpl_pkg::BYTE_W-1:0]  i_in_byte,
    input logic                         i_in_last,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [srpl_pkg::BYTE_W-1:0]  o_out_byte,
    input logic                         o_byte_present,
    input logic                         o_out_last,
    input logic [srpl_pkg::TOTAL_W-1:0] o_replace_total,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [srpl_pkg::APB_AW-1:0]  paddr,
    input logic [srpl_pkg::APB_DW-1:0]  pwdata,
    input logic [srpl_pkg::APB_DW-1:0]  prdata,
    input logic                         pready
);
    import srpl_pkg::*;

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte) &&
            $stable(o_out_last) && $stable(o_replace_total))
        else $error("stalled output word changed");

    // A count-only word closes the stream and carries a zero byte
    a_count_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_byte_present |-> o_out_last && (o_out_byte == '0))
        else $error("count-only word not last or byte not zero");

    // The count never falls within a stream
    a_total_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_last) ##1 o_out_valid |->
            o_replace_total >= $past(o_replace_total))
        else $error("replacement count fell within a stream");

    // Drop output valid after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind stream_fixed_string_replace_unit srpl_checker u_checker (.*);
